FILE: rtl/h2r_pkg.sv
// Package for the 8-bit HSV to RGB converter: payload structs, stage structs,
// sector codes and the divide-by-255 helpers. No dependencies.
package h2r_pkg;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Sector codes, in order around the hue circle.
  localparam logic [2:0] SECT_RY = 3'd0;
  localparam logic [2:0] SECT_YG = 3'd1;
  localparam logic [2:0] SECT_GC = 3'd2;
  localparam logic [2:0] SECT_CB = 3'd3;
  localparam logic [2:0] SECT_BM = 3'd4;
  localparam logic [2:0] SECT_MR = 3'd5;
  localparam logic [2:0] SECT_WRAP = 3'd6;

  localparam logic [7:0]  FULL_LEVEL  = 8'd255;
  localparam logic [15:0] FULL_SQUARE = 16'd65025;

  // Reciprocals of 255 for exact truncating division of 16-bit and 24-bit values.
  localparam logic [16:0] RECIP16 = 17'd65794;
  localparam logic [24:0] RECIP24 = 25'd16843010;

  typedef struct packed {
    logic        grey;
    logic [2:0]  sector;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic [15:0] sr;
    logic [15:0] st;
  } dec_t;

  typedef struct packed {
    logic        grey;
    logic [2:0]  sector;
    logic [7:0]  val;
    logic [15:0] mp;
    logic [23:0] mq;
    logic [23:0] mt;
  } prod_t;

  function automatic logic [7:0] div255_16(input logic [15:0] x);
    logic [32:0] prod;
    prod = {17'b0, x} * {16'b0, RECIP16};
    return prod[31:24];
  endfunction

  function automatic logic [15:0] div255_24(input logic [23:0] x);
    logic [48:0] prod;
    prod = {25'b0, x} * {24'b0, RECIP24};
    return prod[47:32];
  endfunction

endpackage

FILE: rtl/h2r_decode.sv
// First pipeline stage: splits the hue into sector and remainder and forms
// the saturation products. Depends on h2r_pkg.
module h2r_decode
  import h2r_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  hsv_t hsv,
  output logic dec_valid,
  output dec_t dec
);

  logic [10:0] scaled;
  logic [2:0]  cnt;
  logic [10:0] rem_full;
  logic [7:0]  rem;
  dec_t        dec_next;

  always_comb begin
    scaled = {3'b0, hsv.hue} * 11'd6;
    cnt = SECT_RY;
    for (int k = 1; k <= 6; k++) begin
      if (scaled >= 11'(k * 255)) begin
        cnt = 3'(k);
      end
    end
    rem_full = scaled - ({8'b0, cnt} * 11'd255);
    rem = rem_full[7:0];
    dec_next.grey = (hsv.saturation == 8'd0);
    dec_next.sector = (cnt == SECT_WRAP) ? SECT_MR : cnt;
    dec_next.sat = hsv.saturation;
    dec_next.val = hsv.brightness;
    dec_next.sr = {8'b0, hsv.saturation} * {8'b0, rem};
    dec_next.st = {8'b0, hsv.saturation} * {8'b0, FULL_LEVEL - rem};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else begin
      dec_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    dec <= dec_next;
  end

endmodule

FILE: rtl/h2r_scale.sv
// Second pipeline stage: scales the three levels by the brightness.
// Depends on h2r_pkg.
module h2r_scale
  import h2r_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  dec_valid,
  input  dec_t  dec,
  output logic  prod_valid,
  output prod_t prod
);

  prod_t prod_next;

  always_comb begin
    prod_next.grey = dec.grey;
    prod_next.sector = dec.sector;
    prod_next.val = dec.val;
    prod_next.mp = {8'b0, dec.val} * {8'b0, FULL_LEVEL - dec.sat};
    prod_next.mq = {16'b0, dec.val} * {8'b0, FULL_SQUARE - dec.sr};
    prod_next.mt = {16'b0, dec.val} * {8'b0, FULL_SQUARE - dec.st};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
  end

endmodule

FILE: rtl/h2r_norm.sv
// Third and fourth pipeline stages: divide p by 255 once and q and t twice,
// then route them by sector, or all to val when grey. Depends on h2r_pkg.
module h2r_norm
  import h2r_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  prod_valid,
  input  prod_t prod,
  output logic  done,
  output rgb_t  rgb
);

  typedef struct packed {
    logic        grey;
    logic [2:0]  sector;
    logic [7:0]  val;
    logic [7:0]  p;
    logic [15:0] yq;
    logic [15:0] yt;
  } half_t;

  logic  half_valid;
  half_t half;
  half_t half_next;
  logic [7:0] q;
  logic [7:0] t;
  rgb_t rgb_next;

  always_comb begin
    half_next.grey = prod.grey;
    half_next.sector = prod.sector;
    half_next.val = prod.val;
    half_next.p = div255_16(prod.mp);
    half_next.yq = div255_24(prod.mq);
    half_next.yt = div255_24(prod.mt);
  end

  always_comb begin
    q = div255_16(half.yq);
    t = div255_16(half.yt);
    case (half.sector)
      SECT_RY: rgb_next = '{red: half.val, green: t,        blue: half.p};
      SECT_YG: rgb_next = '{red: q,        green: half.val, blue: half.p};
      SECT_GC: rgb_next = '{red: half.p,   green: half.val, blue: t};
      SECT_CB: rgb_next = '{red: half.p,   green: q,        blue: half.val};
      SECT_BM: rgb_next = '{red: t,        green: half.p,   blue: half.val};
      default: rgb_next = '{red: half.val, green: half.p,   blue: q};
    endcase
    if (half.grey) begin
      rgb_next = '{red: half.val, green: half.val, blue: half.val};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_valid <= 1'b0;
      done <= 1'b0;
    end else begin
      half_valid <= prod_valid;
      done <= half_valid;
    end
  end

  always_ff @(posedge clk) begin
    half <= half_next;
    rgb <= rgb_next;
  end

endmodule

FILE: rtl/hsv_to_rgb_8bit_top.sv
// 8-bit HSV to RGB converter, four register stages.
// A color taken passes through the decode, scale, half and rgb registers in
// order, and shows on rgb with done high when it leaves the last of them.
// Throughput: one color per clock while busy is low; busy is high only in reset.
// Reset clears the stage valid bits, so no transfer started before it appears.
// The receiver cannot stall, so nothing is held back. Depends on h2r_pkg.
module hsv_to_rgb_8bit_top
  import h2r_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  hsv_t hsv,
  output logic done,
  output rgb_t rgb
);

  logic  accept;
  logic  dec_valid;
  dec_t  dec;
  logic  prod_valid;
  prod_t prod;

  assign busy = rst;
  assign accept = start & ~busy;

  h2r_decode u_decode (
    .clk(clk),
    .rst(rst),
    .in_valid(accept),
    .hsv(hsv),
    .dec_valid(dec_valid),
    .dec(dec)
  );

  h2r_scale u_scale (
    .clk(clk),
    .rst(rst),
    .dec_valid(dec_valid),
    .dec(dec),
    .prod_valid(prod_valid),
    .prod(prod)
  );

  h2r_norm u_norm (
    .clk(clk),
    .rst(rst),
    .prod_valid(prod_valid),
    .prod(prod),
    .done(done),
    .rgb(rgb)
  );

endmodule

FILE: rtl/h2r_checker.sv
// Port-level checks for the HSV to RGB converter, bound to the top level.
// Depends on h2r_pkg and hsv_to_rgb_8bit_top.
module h2r_checker
  import h2r_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input hsv_t hsv,
  input logic done,
  input rgb_t rgb
);

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done == ($past(start && !busy, 4) && !$past(rst, 1) && !$past(rst, 2) &&
             !$past(rst, 3)))
    else $error("done does not follow an accepted transfer by four cycles");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    (done && $past(hsv.saturation, 4) == 8'd0) |->
      (rgb.red == $past(hsv.brightness, 4) && rgb.green == $past(hsv.brightness, 4) &&
       rgb.blue == $past(hsv.brightness, 4)))
    else $error("zero saturation did not give grey");

  a_max_channel: assert property (@(posedge clk) disable iff (rst)
    done |-> (rgb.red == $past(hsv.brightness, 4) || rgb.green == $past(hsv.brightness, 4) ||
              rgb.blue == $past(hsv.brightness, 4)))
    else $error("no channel carries the brightness");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    done |-> (rgb.red <= $past(hsv.brightness, 4) && rgb.green <= $past(hsv.brightness, 4) &&
              rgb.blue <= $past(hsv.brightness, 4)))
    else $error("a channel exceeds the brightness");

endmodule

bind hsv_to_rgb_8bit_top h2r_checker u_h2r_checker (.*);
